### sv/gwlr_pkg.sv
// Shared types, constants and cosine table generator for the wave LED renderer.
package gwlr_pkg;

  // Default geometry.
  localparam int STRIP_LENGTH_DEF   = 32;
  localparam int STRIP_START_DEF    = 0;
  localparam int LED_TOTAL_DEF      = 64;
  localparam int COS_TABLE_BITS_DEF = 10;

  // Queue depths.
  localparam int FRM_Q_DEPTH = 2;
  localparam int PIX_Q_DEPTH = 4;

  localparam int NUM_WAVES = 3;
  localparam int PHASE_W   = 24;
  localparam int IDX_W     = 10;
  localparam int AMP_W     = 8;
  localparam int RATE_W    = 16;
  localparam int ELAPSED_W = 16;
  localparam int COLOR_W   = 8;
  localparam int COS_W     = 16;

  // Wavenumbers in 2^-24 turn per LED: 0.5, 1.2 and 3.5 rad.
  localparam logic [NUM_WAVES-1:0][PHASE_W-1:0] WAVE_K =
    {24'd9345619, 24'd3204212, 24'd1335088};

  localparam longint unsigned Q30_ONE     = 64'd1 << 30;
  localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;
  localparam longint unsigned COS_FULL    = 64'd32767;

  typedef enum logic [2:0] {
    CFG_AMP_SWELL      = 3'd0,
    CFG_AMP_SECONDARY  = 3'd1,
    CFG_AMP_CHOP       = 3'd2,
    CFG_RATE_SWELL     = 3'd3,
    CFG_RATE_SECONDARY = 3'd4,
    CFG_RATE_CHOP      = 3'd5,
    CFG_THEME_HUE      = 3'd6,
    CFG_THEME_SAT      = 3'd7
  } cfg_reg_e;

  typedef enum logic [0:0] {
    BK_IDLE = 1'b0,
    BK_RUN  = 1'b1
  } bk_state_e;

  typedef logic [NUM_WAVES-1:0][PHASE_W-1:0] phase_t;

  typedef struct packed {
    logic [NUM_WAVES-1:0][AMP_W-1:0]  amp;
    logic [NUM_WAVES-1:0][RATE_W-1:0] rate;
    logic [COLOR_W-1:0]               hue;
    logic [COLOR_W-1:0]               sat;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    amp:  {8'd38, 8'd102, 8'd205},
    rate: {16'd13351, 16'd6676, 16'd3204},
    hue:  8'd0,
    sat:  8'd255
  };

  typedef struct packed {
    logic [IDX_W-1:0]   idx;
    logic [COLOR_W-1:0] bright;
    logic               last;
  } pix_t;

  // Q30 product, elaboration only.
  function automatic longint unsigned mul_q30(input longint unsigned a,
                                              input longint unsigned b);
    return (a * b) >> 30;
  endfunction

  function automatic longint unsigned one_minus(input longint unsigned sub);
    return (sub >= Q30_ONE) ? 64'd0 : Q30_ONE - sub;
  endfunction

  // One cosine table entry, Q1.15, from a Taylor series in Q30.
  function automatic logic signed [COS_W-1:0] cos_entry(input int unsigned tbl_bits,
                                                        input int unsigned j);
    longint unsigned qmask;
    longint unsigned quad;
    longint unsigned r;
    longint unsigned phi;
    longint unsigned p2;
    longint unsigned c;
    longint unsigned s;
    longint unsigned v;
    longint unsigned mag;
    logic signed [COS_W-1:0] m16;
    qmask = (64'd1 << (tbl_bits - 2)) - 64'd1;
    quad  = (64'(j) >> (tbl_bits - 2)) & 64'd3;
    r     = 64'(j) & qmask;
    phi   = (r * HALF_PI_Q30) >> (tbl_bits - 2);
    p2    = mul_q30(phi, phi);
    c = one_minus(mul_q30(p2, Q30_ONE) / 64'd132);
    s = one_minus(mul_q30(p2, Q30_ONE) / 64'd156);
    c = one_minus(mul_q30(p2, c) / 64'd90);
    s = one_minus(mul_q30(p2, s) / 64'd110);
    c = one_minus(mul_q30(p2, c) / 64'd56);
    s = one_minus(mul_q30(p2, s) / 64'd72);
    c = one_minus(mul_q30(p2, c) / 64'd30);
    s = one_minus(mul_q30(p2, s) / 64'd42);
    c = one_minus(mul_q30(p2, c) / 64'd12);
    s = one_minus(mul_q30(p2, s) / 64'd20);
    c = one_minus(mul_q30(p2, c) / 64'd2);
    s = one_minus(mul_q30(p2, s) / 64'd6);
    s = mul_q30(phi, s);
    v = (quad == 64'd0 || quad == 64'd2) ? c : s;
    if (v > Q30_ONE) v = Q30_ONE;
    mag = (v * COS_FULL + (64'd1 << 29)) >> 30;
    m16 = COS_W'(mag);
    return (quad == 64'd1 || quad == 64'd2) ? -m16 : m16;
  endfunction

endpackage

### sv/gwlr_fifo.sv
// Small register-based show-ahead FIFO.
module gwlr_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [WIDTH-1:0] data_o,
  output logic             empty_o
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == CNT_W'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

### sv/gwlr_front.sv
// Front end: takes frame items and advances the three wave phases.
module gwlr_front (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  gwlr_pkg::cfg_t                    cfg_i,
  input  logic                              push_i,
  input  logic [gwlr_pkg::ELAPSED_W-1:0]    elapsed_ms_i,
  output logic                              full_o,
  input  logic                              frm_full_i,
  output logic                              frm_push_o,
  output gwlr_pkg::phase_t                  frm_phase_o
);

  localparam int PROD_W = gwlr_pkg::RATE_W + gwlr_pkg::ELAPSED_W;

  logic                           e_v_q, e_v_d;
  logic [gwlr_pkg::ELAPSED_W-1:0] elapsed_q;
  logic                           m_v_q, m_v_d;
  gwlr_pkg::phase_t               prod_q;
  gwlr_pkg::phase_t               phase_q;
  gwlr_pkg::phase_t               phase_d;
  logic                           m_free, e_move, accept;
  logic [PROD_W-1:0]              prod_full [gwlr_pkg::NUM_WAVES];

  assign frm_push_o = m_v_q && !frm_full_i;
  assign m_free     = !m_v_q || frm_push_o;
  assign e_move     = e_v_q && m_free;
  assign full_o     = e_v_q && !m_free;
  assign accept     = push_i && !full_o;
  assign e_v_d      = accept || (e_v_q && !e_move);
  assign m_v_d      = e_move || (m_v_q && !frm_push_o);

  always_comb begin
    for (int w = 0; w < gwlr_pkg::NUM_WAVES; w++) begin
      prod_full[w] = PROD_W'(cfg_i.rate[w]) * PROD_W'(elapsed_q);
      // Phase wraps modulo one turn.
      phase_d[w]   = phase_q[w] + prod_q[w];
    end
  end

  assign frm_phase_o = phase_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      e_v_q   <= 1'b0;
      m_v_q   <= 1'b0;
      phase_q <= '0;
    end else begin
      e_v_q <= e_v_d;
      m_v_q <= m_v_d;
      if (frm_push_o) begin
        phase_q <= phase_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      elapsed_q <= elapsed_ms_i;
    end
    if (e_move) begin
      for (int w = 0; w < gwlr_pkg::NUM_WAVES; w++) begin
        prod_q[w] <= prod_full[w][gwlr_pkg::PHASE_W-1:0];
      end
    end
  end

endmodule

### sv/gwlr_back.sv
// Back end: LED sequencer, cosine lookup, normalizing divider and cube.
module gwlr_back #(
  parameter int STRIP_LENGTH   = gwlr_pkg::STRIP_LENGTH_DEF,
  parameter int STRIP_START    = gwlr_pkg::STRIP_START_DEF,
  parameter int LED_TOTAL      = gwlr_pkg::LED_TOTAL_DEF,
  parameter int COS_TABLE_BITS = gwlr_pkg::COS_TABLE_BITS_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  gwlr_pkg::cfg_t   cfg_i,
  input  logic             frm_valid_i,
  input  gwlr_pkg::phase_t frm_phase_i,
  output logic             frm_pop_o,
  input  logic             pix_full_i,
  output logic             pix_push_o,
  output gwlr_pkg::pix_t   pix_o
);

  localparam int TABLE_SIZE = 1 << COS_TABLE_BITS;
  localparam int IDX_W      = gwlr_pkg::IDX_W;
  localparam int NW         = gwlr_pkg::NUM_WAVES;
  localparam int N_LEDS     = (LED_TOTAL > STRIP_START) ?
    (((LED_TOTAL - STRIP_START) < STRIP_LENGTH) ? (LED_TOTAL - STRIP_START) : STRIP_LENGTH)
    : 0;
  localparam bit HAS_LEDS = (N_LEDS > 0);
  localparam logic [IDX_W-1:0] FIRST_IDX = IDX_W'(STRIP_START);
  localparam logic [IDX_W-1:0] LAST_IDX  = HAS_LEDS ? IDX_W'(STRIP_START + N_LEDS - 1) : '0;

  localparam int TOT_W     = gwlr_pkg::AMP_W + 2;   // sum of three amplitudes
  localparam int BIAS_W    = TOT_W + 15;            // 32767 * total
  localparam int NUM_W     = TOT_W + 16;            // 65534 * total bound
  localparam int REM_W     = NUM_W + 1;
  localparam int PROD_W    = gwlr_pkg::AMP_W + 1 + gwlr_pkg::COS_W;
  localparam int SUM_W     = NUM_W + 2;
  localparam int QUO_W     = 17;                    // quotient 0..65536
  localparam int H_W       = QUO_W - 1;
  localparam int DIV_STEPS = QUO_W;
  localparam int CUBE_W    = 3 * H_W;
  localparam int SCL_W     = CUBE_W + gwlr_pkg::COLOR_W;

  typedef struct packed {
    logic [IDX_W-1:0] idx;
    logic             last;
  } tag_t;

  // Cosine ROM, built at elaboration.
  logic signed [gwlr_pkg::COS_W-1:0] cos_rom [TABLE_SIZE];
  for (genvar j = 0; j < TABLE_SIZE; j++) begin : g_rom
    assign cos_rom[j] = gwlr_pkg::cos_entry(COS_TABLE_BITS, j);
  end

  gwlr_pkg::bk_state_e state_q, state_d;
  logic                en, issue, load;
  gwlr_pkg::phase_t    theta_q;
  logic [IDX_W-1:0]    idx_q;

  logic [TOT_W-1:0]    total;
  logic                zero_q;
  logic [BIAS_W-1:0]   bias_q;
  logic [NUM_W-1:0]    den_q;

  logic                                p0_v_q;
  logic [NW-1:0][COS_TABLE_BITS-1:0]   p0_addr_q;
  tag_t                                p0_tag_q;
  logic                                p1_v_q;
  logic signed [gwlr_pkg::COS_W-1:0]   p1_cos_q [NW];
  tag_t                                p1_tag_q;
  logic                                p2_v_q;
  logic signed [PROD_W-1:0]            p2_prod_q [NW];
  tag_t                                p2_tag_q;
  logic                                p3_v_q;
  logic [NUM_W-1:0]                    p3_num_q;
  tag_t                                p3_tag_q;
  logic signed [SUM_W-1:0]             num_x;

  logic [DIV_STEPS-1:0]  dv_v_q;
  logic [REM_W-1:0]      dv_rem_q [DIV_STEPS-1];
  logic [QUO_W-1:0]      dv_quo_q [DIV_STEPS];
  tag_t                  dv_tag_q [DIV_STEPS];
  logic [REM_W-1:0]      dv_t     [DIV_STEPS];
  logic [REM_W-1:0]      dv_diff  [DIV_STEPS];
  logic [DIV_STEPS-1:0]  dv_ge;

  logic                  c1_v_q, c1_full_q;
  logic [H_W-1:0]        c1_h_q;
  logic [2*H_W-1:0]      c1_h2_q;
  tag_t                  c1_tag_q;
  logic                  c2_v_q, c2_full_q;
  logic [CUBE_W-1:0]     c2_h3_q;
  tag_t                  c2_tag_q;
  logic                  c3_v_q;
  gwlr_pkg::pix_t        c3_pix_q;
  logic [SCL_W-1:0]      scaled;
  logic [gwlr_pkg::COLOR_W-1:0] bright;

  // Whole pipeline moves together; it holds while the result queue is full.
  assign en         = !pix_full_i;
  assign pix_push_o = c3_v_q && en;
  assign pix_o      = c3_pix_q;

  // Sequencer: next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      gwlr_pkg::BK_IDLE: begin
        if (frm_valid_i) begin
          state_d = HAS_LEDS ? gwlr_pkg::BK_RUN : gwlr_pkg::BK_IDLE;
        end
      end
      gwlr_pkg::BK_RUN: begin
        if (en && idx_q == LAST_IDX) begin
          state_d = gwlr_pkg::BK_IDLE;
        end
      end
      default: state_d = gwlr_pkg::BK_IDLE;
    endcase
  end

  // Sequencer: outputs.
  always_comb begin
    load  = 1'b0;
    issue = 1'b0;
    case (state_q)
      gwlr_pkg::BK_IDLE: load  = frm_valid_i;
      gwlr_pkg::BK_RUN:  issue = en;
      default: ;
    endcase
  end

  assign frm_pop_o = load;

  // Amplitude totals; user keeps them stable while frames run; not enforced.
  assign total = TOT_W'(cfg_i.amp[0]) + TOT_W'(cfg_i.amp[1]) + TOT_W'(cfg_i.amp[2]);

  always_ff @(posedge clk_i) begin
    zero_q <= (total == '0);
    bias_q <= (BIAS_W'(total) << 15) - BIAS_W'(total);
    den_q  <= (NUM_W'(total) << 16) - (NUM_W'(total) << 1);
  end

  // Divider steps: one quotient bit per stage, MSB first.
  for (genvar s = 0; s < DIV_STEPS; s++) begin : g_div
    if (s == 0) begin : g_first
      assign dv_t[s] = REM_W'(p3_num_q);
    end else begin : g_next
      assign dv_t[s] = {dv_rem_q[s-1][REM_W-2:0], 1'b0};
    end
    assign dv_ge[s]   = (dv_t[s] >= REM_W'(den_q));
    assign dv_diff[s] = dv_t[s] - REM_W'(den_q);
  end

  always_comb begin
    num_x = SUM_W'(p2_prod_q[0]) + SUM_W'(p2_prod_q[1]) + SUM_W'(p2_prod_q[2])
          + $signed({3'b000, bias_q});
  end

  always_comb begin
    scaled = (SCL_W'(c2_h3_q) << gwlr_pkg::COLOR_W) - SCL_W'(c2_h3_q);
    if (zero_q) begin
      bright = '0;
    end else if (c2_full_q) begin
      bright = '1;
    end else begin
      bright = scaled[SCL_W-1 -: gwlr_pkg::COLOR_W];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= gwlr_pkg::BK_IDLE;
      p0_v_q  <= 1'b0;
      p1_v_q  <= 1'b0;
      p2_v_q  <= 1'b0;
      p3_v_q  <= 1'b0;
      dv_v_q  <= '0;
      c1_v_q  <= 1'b0;
      c2_v_q  <= 1'b0;
      c3_v_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      if (en) begin
        p0_v_q <= issue;
        p1_v_q <= p0_v_q;
        p2_v_q <= p1_v_q;
        p3_v_q <= p2_v_q;
        dv_v_q <= {dv_v_q[DIV_STEPS-2:0], p3_v_q};
        c1_v_q <= dv_v_q[DIV_STEPS-1];
        c2_v_q <= c1_v_q;
        c3_v_q <= c2_v_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      theta_q <= frm_phase_i;
      idx_q   <= FIRST_IDX;
    end else if (issue) begin
      for (int w = 0; w < NW; w++) begin
        theta_q[w] <= theta_q[w] + gwlr_pkg::WAVE_K[w];
      end
      idx_q <= idx_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int w = 0; w < NW; w++) begin
        p0_addr_q[w] <= theta_q[w][gwlr_pkg::PHASE_W-1 -: COS_TABLE_BITS];
        p1_cos_q[w]  <= cos_rom[p0_addr_q[w]];
        p2_prod_q[w] <= $signed({1'b0, cfg_i.amp[w]}) * p1_cos_q[w];
      end
      p0_tag_q <= '{idx: idx_q, last: (idx_q == LAST_IDX)};
      p1_tag_q <= p0_tag_q;
      p2_tag_q <= p1_tag_q;
      p3_tag_q <= p2_tag_q;
      p3_num_q <= num_x[NUM_W-1:0];

      dv_quo_q[0] <= QUO_W'(dv_ge[0]);
      dv_tag_q[0] <= p3_tag_q;
      for (int s = 1; s < DIV_STEPS; s++) begin
        dv_quo_q[s] <= {dv_quo_q[s-1][QUO_W-2:0], dv_ge[s]};
        dv_tag_q[s] <= dv_tag_q[s-1];
      end
      for (int s = 0; s < DIV_STEPS - 1; s++) begin
        dv_rem_q[s] <= dv_ge[s] ? dv_diff[s] : dv_t[s];
      end

      c1_full_q <= dv_quo_q[DIV_STEPS-1][QUO_W-1];
      c1_h_q    <= dv_quo_q[DIV_STEPS-1][H_W-1:0];
      c1_h2_q   <= (2*H_W)'(dv_quo_q[DIV_STEPS-1][H_W-1:0])
                 * (2*H_W)'(dv_quo_q[DIV_STEPS-1][H_W-1:0]);
      c1_tag_q  <= dv_tag_q[DIV_STEPS-1];

      c2_full_q <= c1_full_q;
      c2_h3_q   <= CUBE_W'(c1_h2_q) * CUBE_W'(c1_h_q);
      c2_tag_q  <= c1_tag_q;

      c3_pix_q  <= '{idx: c2_tag_q.idx, bright: bright, last: c2_tag_q.last};
    end
  end

endmodule

### sv/gerstner_wave_led_renderer.sv
// Top level of the three-wave LED renderer: config registers and the two halves.
//
// Usage:
//   Frame channel: drive elapsed_ms_i with push high; the frame is taken at a
//   clock edge where push is high and full is low. Each frame advances the
//   three wave phases and produces one result per LED position inside the
//   strip, ending with last set (a strip that lies wholly past the LED total
//   produces no results but still advances the phases).
//   Result channel: while empty is low the oldest result sits on led_index_o,
//   hue_o, sat_o, brightness_o and last_o; pop high takes it.
//   Config channel: cfg_ready_o is always high; a transfer writes register
//   cfg_index_i with cfg_data_i. Write only while no frame is in flight.
//   Timing: between a frame transfer and its first result lie one more front
//   stage, the frame queue write, one sequencer load, 24 pipeline stages of
//   which 17 are the normalizing divider, and the result queue write. The LED
//   sequencer issues one position per cycle while the result queue is not
//   full; frames overlap in flight.
//   Stall: when pop stays low the result queue fills, the back pipeline
//   freezes, the two-entry frame queue fills and full rises.
//   Reset: phases clear to zero, registers take their defaults, all queues empty.
module gerstner_wave_led_renderer #(
  parameter int STRIP_LENGTH   = gwlr_pkg::STRIP_LENGTH_DEF,
  parameter int STRIP_START    = gwlr_pkg::STRIP_START_DEF,
  parameter int LED_TOTAL      = gwlr_pkg::LED_TOTAL_DEF,
  parameter int COS_TABLE_BITS = gwlr_pkg::COS_TABLE_BITS_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            push,
  input  logic [gwlr_pkg::ELAPSED_W-1:0]  elapsed_ms_i,
  output logic                            full,
  output logic                            empty,
  input  logic                            pop,
  output logic [gwlr_pkg::IDX_W-1:0]      led_index_o,
  output logic [gwlr_pkg::COLOR_W-1:0]    hue_o,
  output logic [gwlr_pkg::COLOR_W-1:0]    sat_o,
  output logic [gwlr_pkg::COLOR_W-1:0]    brightness_o,
  output logic                            last_o,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [2:0]                      cfg_index_i,
  input  logic [gwlr_pkg::RATE_W-1:0]     cfg_data_i
);

  gwlr_pkg::cfg_t   cfg_q, cfg_d;
  logic             cfg_we;

  logic             frm_push, frm_full, frm_pop, frm_empty;
  gwlr_pkg::phase_t frm_phase_in, frm_phase_out;

  logic             pix_push, pix_full;
  gwlr_pkg::pix_t   pix_in, pix_out;

  // Config registers; always ready.
  assign cfg_ready_o = 1'b1;
  assign cfg_we      = cfg_valid_i && cfg_ready_o;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we) begin
      case (gwlr_pkg::cfg_reg_e'(cfg_index_i))
        gwlr_pkg::CFG_AMP_SWELL:      cfg_d.amp[0]  = cfg_data_i[gwlr_pkg::AMP_W-1:0];
        gwlr_pkg::CFG_AMP_SECONDARY:  cfg_d.amp[1]  = cfg_data_i[gwlr_pkg::AMP_W-1:0];
        gwlr_pkg::CFG_AMP_CHOP:       cfg_d.amp[2]  = cfg_data_i[gwlr_pkg::AMP_W-1:0];
        gwlr_pkg::CFG_RATE_SWELL:     cfg_d.rate[0] = cfg_data_i;
        gwlr_pkg::CFG_RATE_SECONDARY: cfg_d.rate[1] = cfg_data_i;
        gwlr_pkg::CFG_RATE_CHOP:      cfg_d.rate[2] = cfg_data_i;
        gwlr_pkg::CFG_THEME_HUE:      cfg_d.hue     = cfg_data_i[gwlr_pkg::COLOR_W-1:0];
        gwlr_pkg::CFG_THEME_SAT:      cfg_d.sat     = cfg_data_i[gwlr_pkg::COLOR_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= gwlr_pkg::CFG_RESET;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // Front: frame transfers and phase update.
  gwlr_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .push_i       (push),
    .elapsed_ms_i (elapsed_ms_i),
    .full_o       (full),
    .frm_full_i   (frm_full),
    .frm_push_o   (frm_push),
    .frm_phase_o  (frm_phase_in)
  );

  // Frame queue between front and back.
  gwlr_fifo #(
    .WIDTH ($bits(gwlr_pkg::phase_t)),
    .DEPTH (gwlr_pkg::FRM_Q_DEPTH)
  ) u_frm_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (frm_push),
    .data_i  (frm_phase_in),
    .full_o  (frm_full),
    .pop_i   (frm_pop),
    .data_o  (frm_phase_out),
    .empty_o (frm_empty)
  );

  // Back: per-LED rendering pipeline.
  gwlr_back #(
    .STRIP_LENGTH   (STRIP_LENGTH),
    .STRIP_START    (STRIP_START),
    .LED_TOTAL      (LED_TOTAL),
    .COS_TABLE_BITS (COS_TABLE_BITS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .frm_valid_i (!frm_empty),
    .frm_phase_i (frm_phase_out),
    .frm_pop_o   (frm_pop),
    .pix_full_i  (pix_full),
    .pix_push_o  (pix_push),
    .pix_o       (pix_in)
  );

  // Result queue toward the consumer.
  gwlr_fifo #(
    .WIDTH ($bits(gwlr_pkg::pix_t)),
    .DEPTH (gwlr_pkg::PIX_Q_DEPTH)
  ) u_pix_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (pix_push),
    .data_i  (pix_in),
    .full_o  (pix_full),
    .pop_i   (pop),
    .data_o  (pix_out),
    .empty_o (empty)
  );

  // Hue, saturation from config; user changes them only while idle, unenforced.
  assign led_index_o  = pix_out.idx;
  assign brightness_o = pix_out.bright;
  assign last_o       = pix_out.last;
  assign hue_o        = cfg_q.hue;
  assign sat_o        = cfg_q.sat;

endmodule

### tb/gwlr_frame_checker.sv
`timescale 1ns / 100ps
// Frame predictor and LED result checker for the wave renderer testbench.
module gwlr_frame_checker
  import gwlr_pkg::*;
#(
  parameter int STRIP_LENGTH   = STRIP_LENGTH_DEF,
  parameter int STRIP_START    = STRIP_START_DEF,
  parameter int LED_TOTAL      = LED_TOTAL_DEF,
  parameter int COS_TABLE_BITS = COS_TABLE_BITS_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push,
  input  logic                 full,
  input  logic [ELAPSED_W-1:0] elapsed_ms_i,
  input  logic                 empty,
  input  logic                 pop,
  input  logic [IDX_W-1:0]     led_index_o,
  input  logic [COLOR_W-1:0]   hue_o,
  input  logic [COLOR_W-1:0]   sat_o,
  input  logic [COLOR_W-1:0]   brightness_o,
  input  logic                 last_o,
  input  logic                 cfg_valid_i,
  input  logic                 cfg_ready_o,
  input  logic [2:0]           cfg_index_i,
  input  logic [RATE_W-1:0]    cfg_data_i,
  output int unsigned          fail_count_o,
  output int unsigned          expected_left_o
);

  localparam int LUT_SIZE = 1 << COS_TABLE_BITS;
  localparam int MAX_PER_FRAME = 64;
  localparam logic [5:0][7:0] COS_DIV = {8'd2, 8'd12, 8'd30, 8'd56, 8'd90, 8'd132};
  localparam logic [5:0][7:0] SIN_DIV = {8'd6, 8'd20, 8'd42, 8'd72, 8'd110, 8'd156};

  typedef struct packed {
    logic [IDX_W-1:0]   idx;
    logic [COLOR_W-1:0] hue;
    logic [COLOR_W-1:0] sat;
    logic [COLOR_W-1:0] bright;
    logic               last;
  } led_px_t;

  logic signed [COS_W-1:0] cos_lut [LUT_SIZE];

  logic [AMP_W-1:0]   amp_q   [NUM_WAVES];
  logic [RATE_W-1:0]  step_q  [NUM_WAVES];
  logic [PHASE_W-1:0] phase_acc [NUM_WAVES];
  logic [COLOR_W-1:0] hue_q;
  logic [COLOR_W-1:0] sat_q;

  led_px_t     led_expect [$];
  int unsigned mismatches = 0;

  assign fail_count_o = mismatches;

  // Q1.15 cosine table from a Q30 Taylor series, per quadrant
  initial begin : build_cos_lut
    longint unsigned qlen, quad, r, phi, p2, c, s, v, mag, sub;
    qlen = 64'd1 << (COS_TABLE_BITS - 2);
    for (int j = 0; j < LUT_SIZE; j++) begin
      quad = (64'(j) >> (COS_TABLE_BITS - 2)) & 64'd3;
      r    = 64'(j) & (qlen - 64'd1);
      phi  = r * HALF_PI_Q30 / qlen;
      p2   = (phi * phi) >> 30;
      c    = Q30_ONE;
      s    = Q30_ONE;
      for (int n = 0; n < 6; n++) begin
        sub = ((p2 * c) >> 30) / 64'(COS_DIV[n]);
        c   = (sub >= Q30_ONE) ? 64'd0 : Q30_ONE - sub;
        sub = ((p2 * s) >> 30) / 64'(SIN_DIV[n]);
        s   = (sub >= Q30_ONE) ? 64'd0 : Q30_ONE - sub;
      end
      s = (phi * s) >> 30;
      v = (quad == 64'd0 || quad == 64'd2) ? c : s;
      if (v > Q30_ONE) v = Q30_ONE;
      mag = (v * COS_FULL + (64'd1 << 29)) >> 30;
      cos_lut[j] = (quad == 64'd1 || quad == 64'd2) ? -COS_W'(mag) : COS_W'(mag);
    end
  end

  // advance phases, then queue one pixel per in-range strip position
  function automatic void render_frame(input logic [ELAPSED_W-1:0] ms);
    longint unsigned total, theta, num, den, h, bright;
    longint signed   wave_sum, lifted;
    int unsigned     ti;
    int              produced;
    led_px_t         px, held;
    bit              have_held;
    total     = 64'(amp_q[0]) + 64'(amp_q[1]) + 64'(amp_q[2]);
    produced  = 0;
    have_held = 1'b0;
    for (int w = 0; w < NUM_WAVES; w++)
      phase_acc[w] = PHASE_W'(32'(phase_acc[w]) + 32'(step_q[w]) * 32'(ms));
    for (int a = 0; a < STRIP_LENGTH && produced < MAX_PER_FRAME; a++) begin
      if (STRIP_START + a >= LED_TOTAL) continue;
      wave_sum = 0;
      for (int w = 0; w < NUM_WAVES; w++) begin
        theta = (64'(WAVE_K[w]) * 64'(a) + 64'(phase_acc[w])) & 64'hFF_FFFF;
        ti    = int'(theta >> (PHASE_W - COS_TABLE_BITS));
        wave_sum += longint'(amp_q[w]) * longint'(cos_lut[ti]);
      end
      bright = 0;
      if (total != 0) begin
        lifted = wave_sum + longint'(COS_FULL * total);
        num    = (lifted < 0) ? 64'd0 : 64'(lifted);
        den    = 64'd2 * COS_FULL * total;
        h      = (num << 16) / den;
        if (h > 64'd65536) h = 64'd65536;
        bright = (h * h * h * 64'd255) >> 48;
        if (bright > 64'd255) bright = 64'd255;
      end
      px.idx    = IDX_W'(STRIP_START + a);
      px.hue    = hue_q;
      px.sat    = sat_q;
      px.bright = COLOR_W'(bright);
      px.last   = 1'b0;
      if (have_held) led_expect.push_back(held);
      held      = px;
      have_held = 1'b1;
      produced++;
    end
    if (have_held) begin
      held.last = 1'b1;
      led_expect.push_back(held);
    end
  endfunction

  task automatic check_field(input string name, input int unsigned want,
                             input int unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      amp_q[0]  = CFG_RESET.amp[0];
      amp_q[1]  = CFG_RESET.amp[1];
      amp_q[2]  = CFG_RESET.amp[2];
      step_q[0] = CFG_RESET.rate[0];
      step_q[1] = CFG_RESET.rate[1];
      step_q[2] = CFG_RESET.rate[2];
      hue_q     = CFG_RESET.hue;
      sat_q     = CFG_RESET.sat;
      for (int w = 0; w < NUM_WAVES; w++) phase_acc[w] = '0;
      led_expect.delete();
      expected_left_o <= 0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_reg_e'(cfg_index_i))
          CFG_AMP_SWELL:      amp_q[0]  = AMP_W'(cfg_data_i);
          CFG_AMP_SECONDARY:  amp_q[1]  = AMP_W'(cfg_data_i);
          CFG_AMP_CHOP:       amp_q[2]  = AMP_W'(cfg_data_i);
          CFG_RATE_SWELL:     step_q[0] = cfg_data_i;
          CFG_RATE_SECONDARY: step_q[1] = cfg_data_i;
          CFG_RATE_CHOP:      step_q[2] = cfg_data_i;
          CFG_THEME_HUE:      hue_q     = COLOR_W'(cfg_data_i);
          CFG_THEME_SAT:      sat_q     = COLOR_W'(cfg_data_i);
          default: ;
        endcase
      end
      // result side first so a same-edge frame can never mask a stray result
      if (pop && !empty) begin
        if (led_expect.size() == 0) begin
          $display("%0t: unexpected LED result, expected none, actual index %0d brightness %0d",
                   $time, led_index_o, brightness_o);
          mismatches++;
        end else begin
          led_px_t want;
          want = led_expect.pop_front();
          check_field("led_index", want.idx, led_index_o);
          check_field("hue", want.hue, hue_o);
          check_field("sat", want.sat, sat_o);
          check_field("brightness", want.bright, brightness_o);
          check_field("last", want.last, last_o);
        end
      end
      if (push && !full) render_frame(elapsed_ms_i);
      expected_left_o <= led_expect.size();
    end
  end

endmodule

### tb/tb_gerstner_wave_led_renderer.sv
`timescale 1ns / 100ps
// Top of the wave renderer testbench: clock, reset, frame and config stimulus, verdict.
module tb_gerstner_wave_led_renderer;
  import gwlr_pkg::*;

  // Settle margin beyond the path from a frame transfer to its first result.
  localparam int SETTLE_CYCLES = 40;
  // Receiver hold-off long enough to back the whole pipeline up to full.
  localparam int LONG_HOLD     = 400;
  localparam int RANDOM_SETS   = 6;
  localparam int FRAMES_PER_SET = 50;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 push;
  logic [ELAPSED_W-1:0] elapsed_ms_i;
  logic                 full;
  logic                 empty;
  logic                 pop;
  logic [IDX_W-1:0]     led_index_o;
  logic [COLOR_W-1:0]   hue_o;
  logic [COLOR_W-1:0]   sat_o;
  logic [COLOR_W-1:0]   brightness_o;
  logic                 last_o;
  logic                 cfg_valid_i;
  logic                 cfg_ready_o;
  logic [2:0]           cfg_index_i;
  logic [RATE_W-1:0]    cfg_data_i;

  int unsigned fail_count;
  int unsigned expected_left;

  // Stimulus asks the result side for a long hold-off by bumping this.
  int unsigned sink_hold_req = 0;
  // Remaining frames in a no-gap stretch on the frame side.
  int send_burst = 0;

  gerstner_wave_led_renderer dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push         (push),
    .elapsed_ms_i (elapsed_ms_i),
    .full         (full),
    .empty        (empty),
    .pop          (pop),
    .led_index_o  (led_index_o),
    .hue_o        (hue_o),
    .sat_o        (sat_o),
    .brightness_o (brightness_o),
    .last_o       (last_o),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i)
  );

  gwlr_frame_checker u_checker (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .push            (push),
    .full            (full),
    .elapsed_ms_i    (elapsed_ms_i),
    .empty           (empty),
    .pop             (pop),
    .led_index_o     (led_index_o),
    .hue_o           (hue_o),
    .sat_o           (sat_o),
    .brightness_o    (brightness_o),
    .last_o          (last_o),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .fail_count_o    (fail_count),
    .expected_left_o (expected_left)
  );

  // 2 ns period
  always begin
    clk_i = 1'b1;
    #1;
    clk_i = 1'b0;
    #1;
  end

  // Hard stop; the slowest legal run needs about a tenth of this.
  initial begin
    #1_000_000;
    $display("Test completed with failures");
    $finish;
  end

  // Zero or max_val two times in five, otherwise uniform; keeps every bit toggling.
  function automatic int unsigned pick_value(input int unsigned max_val);
    case ($urandom_range(0, 4))
      0:       return 0;
      1:       return max_val;
      default: return $urandom_range(0, max_val);
    endcase
  endfunction

  // One frame transfer: a random gap before it, or none inside a burst stretch.
  task automatic send_frame(input logic [ELAPSED_W-1:0] ms);
    int gap;
    if (send_burst > 0) begin
      send_burst--;
      gap = 0;
    end else if ($urandom_range(0, 9) == 0) begin
      send_burst = $urandom_range(10, 40);
      gap = 0;
    end else begin
      gap = $urandom_range(0, 4);
    end
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    push         <= 1'b1;
    elapsed_ms_i <= ms;
    do @(posedge clk_i); while (full);
  endtask

  // Stop offering frames and wait until every queued LED has been popped,
  // then let the pipeline settle so nothing is still in flight.
  task automatic wait_drained();
    push <= 1'b0;
    @(posedge clk_i);
    while (expected_left != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // Register write transfer; valid stays high across back-to-back writes.
  task automatic write_reg(input cfg_reg_e sel, input logic [RATE_W-1:0] value);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= sel;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
  endtask

  // Full register set, written only with the block idle.
  task automatic set_config(input int unsigned a0, input int unsigned a1,
                            input int unsigned a2, input int unsigned r0,
                            input int unsigned r1, input int unsigned r2,
                            input int unsigned hue, input int unsigned sat);
    wait_drained();
    write_reg(CFG_AMP_SWELL,      RATE_W'(a0));
    write_reg(CFG_AMP_SECONDARY,  RATE_W'(a1));
    write_reg(CFG_AMP_CHOP,       RATE_W'(a2));
    write_reg(CFG_RATE_SWELL,     RATE_W'(r0));
    write_reg(CFG_RATE_SECONDARY, RATE_W'(r1));
    write_reg(CFG_RATE_CHOP,      RATE_W'(r2));
    write_reg(CFG_THEME_HUE,      RATE_W'(hue));
    write_reg(CFG_THEME_SAT,      RATE_W'(sat));
    cfg_valid_i <= 1'b0;
  endtask

  // Result side: random pop gaps, no-gap stretches, and one long hold-off on
  // request so the result and frame queues fill and full rises.
  initial begin : led_sink
    int gap;
    int burst;
    int unsigned holds_done;
    burst      = 0;
    holds_done = 0;
    pop <= 1'b0;
    @(posedge rst_ni);
    forever begin
      if (holds_done != sink_hold_req) begin
        holds_done++;
        gap = LONG_HOLD;
      end else if (burst > 0) begin
        burst--;
        gap = 0;
      end else if ($urandom_range(0, 9) == 0) begin
        burst = $urandom_range(20, 80);
        gap = 0;
      end else begin
        gap = $urandom_range(0, 4);
      end
      if (gap > 0) begin
        pop <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      pop <= 1'b1;
      do @(posedge clk_i); while (empty);
    end
  end

  initial begin : frame_source
    logic [ELAPSED_W-1:0] ms;
    rst_ni       <= 1'b0;
    push         <= 1'b0;
    elapsed_ms_i <= '0;
    cfg_valid_i  <= 1'b0;
    cfg_index_i  <= CFG_AMP_SWELL;
    cfg_data_i   <= '0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset defaults: zero elapsed keeps phases at zero, then field extremes.
    send_frame(16'd0);
    send_frame(16'd1);
    send_frame(16'hFFFF);
    send_frame(16'h5555);
    send_frame(16'hAAAA);

    // Zero total amplitude: every LED must come out dark.
    set_config(0, 0, 0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 255, 0);
    send_frame(16'hFFFF);
    send_frame(16'h1234);
    send_frame(16'd0);

    // Full amplitudes and top rates: phase products wrap past one turn.
    set_config(255, 255, 255, 16'hFFFF, 16'hFFFF, 16'hFFFF, 0, 255);
    send_frame(16'hFFFF);
    send_frame(16'hFFFE);
    send_frame(16'd1);
    send_frame(16'h8000);

    // Single wave, frozen phases: crests reach full scale.
    set_config(255, 0, 0, 0, 0, 0, 8'hAA, 8'h55);
    send_frame(16'd0);
    send_frame(16'h7FFF);

    // Only the short chop wave, minimal rates.
    set_config(0, 0, 255, 1, 1, 1, 8'h55, 8'hAA);
    send_frame(16'd3);
    send_frame(16'hFFFF);
    send_frame(16'h00FF);

    // Random settings, each followed by a run of random frames.
    for (int set_no = 0; set_no < RANDOM_SETS; set_no++) begin
      set_config(pick_value(255), pick_value(255), pick_value(255),
                 pick_value(16'hFFFF), pick_value(16'hFFFF), pick_value(16'hFFFF),
                 pick_value(255), pick_value(255));
      for (int n = 0; n < FRAMES_PER_SET; n++) begin
        // back-pressure: sink holds off while frames keep coming
        if (set_no == 1 && n == 10) sink_hold_req++;
        // sender pause until the result queue has fully drained
        if (set_no == 3 && n == 25) wait_drained();
        case ($urandom_range(0, 7))
          0:       ms = '0;
          1:       ms = '1;
          2, 3, 4: ms = ELAPSED_W'($urandom_range(0, 300));
          default: ms = ELAPSED_W'($urandom());
        endcase
        send_frame(ms);
      end
    end

    wait_drained();
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

### files.f
sv/gwlr_pkg.sv
sv/gwlr_fifo.sv
sv/gwlr_front.sv
sv/gwlr_back.sv
sv/gerstner_wave_led_renderer.sv
tb/gwlr_frame_checker.sv
tb/tb_gerstner_wave_led_renderer.sv
